/* sv/chunk_transition_map_builder_unit_assert.svh */
// assertion macros shared by the block
`ifndef CHUNK_TRANSITION_MAP_BUILDER_UNIT_ASSERT_SVH
`define CHUNK_TRANSITION_MAP_BUILDER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CTMB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CTMB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ctmb_pkg.sv */
package ctmb_pkg;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int SYM_W       = 2;
    localparam int CSIZE_W     = 13;
    localparam int MAP_W       = 8;
    localparam int COUNT_W     = 15;
    localparam int NUM_SYM     = 4;
    localparam int NUM_COUNT   = NUM_SYM * NUM_SYM;
    localparam int IDX_W       = 2 * SYM_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [CSIZE_W-1:0] CSIZE_RESET = CSIZE_W'(256);

    // defaults for top-level parameters
    localparam int MAX_CHUNK_BYTES_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF     = 4;

    // classified byte passed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [SYM_W-1:0]  prev_sym;
        logic              prev_en;
        logic              close;
        logic              eos;
    } item_t;

    // one result record
    typedef struct packed {
        logic             record_bit;
        logic [MAP_W-1:0] chunk_map;
        logic             stream_done;
    } result_t;

    // queue handshake toward a consumer or producer
    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

endpackage

/* sv/ctmb_fifo.sv */
module ctmb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output ctmb_pkg::qstat_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    // pointer and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* sv/ctmb_front.sv */
module ctmb_front #(
    parameter int MAX_CHUNK_BYTES = ctmb_pkg::MAX_CHUNK_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic [ctmb_pkg::BYTE_W-1:0]     data_byte,
    input  logic                            end_of_stream,
    input  logic                            chunk_len_we,
    input  logic [ctmb_pkg::CSIZE_W-1:0]    chunk_len_wdata,
    input  logic                            q_full,
    output logic                            q_push,
    output ctmb_pkg::item_t                 q_item
);

    localparam int BW = $clog2(MAX_CHUNK_BYTES + 1);
    localparam int CW = (BW > ctmb_pkg::CSIZE_W) ? BW : ctmb_pkg::CSIZE_W;
    localparam logic [BW-1:0] BMAX = BW'(MAX_CHUNK_BYTES);
    localparam logic [CW-1:0] CMAX = CW'(MAX_CHUNK_BYTES);

    logic [ctmb_pkg::CSIZE_W-1:0] chunk_len_reg;
    logic [ctmb_pkg::SYM_W-1:0]   prev_sym_reg, prev_sym_next;
    logic                         have_prev_reg, have_prev_next;
    logic [BW-1:0]                bytes_reg, bytes_next;
    logic [BW-1:0]                bytes_inc;
    logic [CW-1:0]                csize_ext, eff_size;
    logic                         close;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_len_reg <= ctmb_pkg::CSIZE_RESET;
        end
        else if (chunk_len_we)
        begin
            chunk_len_reg <= chunk_len_wdata;
        end
    end

    // effective chunk size clamped to 1..max
    always_comb
    begin
        csize_ext = CW'(chunk_len_reg);
        if (csize_ext == '0)
        begin
            eff_size = CW'(1);
        end
        else if (csize_ext > CMAX)
        begin
            eff_size = CMAX;
        end
        else
        begin
            eff_size = csize_ext;
        end
    end

    // classify: byte count and chunk close
    assign bytes_inc = (bytes_reg == BMAX) ? bytes_reg : bytes_reg + 1'b1;
    assign close     = (CW'(bytes_inc) >= eff_size) || end_of_stream;
    assign q_push    = push && !q_full;

    assign q_item.data_byte = data_byte;
    assign q_item.prev_sym  = prev_sym_reg;
    assign q_item.prev_en   = have_prev_reg;
    assign q_item.close     = close;
    assign q_item.eos       = end_of_stream;

    // stream state
    always_comb
    begin
        prev_sym_next  = prev_sym_reg;
        have_prev_next = have_prev_reg;
        bytes_next     = bytes_reg;
        if (q_push)
        begin
            prev_sym_next  = end_of_stream ? '0 : data_byte[ctmb_pkg::SYM_W-1:0];
            have_prev_next = !end_of_stream;
            bytes_next     = close ? '0 : bytes_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sym_reg  <= '0;
            have_prev_reg <= 1'b0;
            bytes_reg     <= '0;
        end
        else
        begin
            prev_sym_reg  <= prev_sym_next;
            have_prev_reg <= have_prev_next;
            bytes_reg     <= bytes_next;
        end
    end

endmodule

/* sv/ctmb_back.sv */
module ctmb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ctmb_pkg::qstat_t  q_stat,
    input  ctmb_pkg::item_t   q_item,
    output logic              q_pop,
    input  logic              res_full,
    output logic              res_push,
    output ctmb_pkg::result_t res
);

    localparam int NC = ctmb_pkg::NUM_COUNT;
    localparam int KW = ctmb_pkg::COUNT_W;

    logic [KW-1:0]              cnt_reg  [NC];
    logic [KW-1:0]              cnt_next [NC];
    logic [KW-1:0]              snap_reg [NC];
    logic                       snap_valid_reg;
    logic                       snap_eos_reg;
    logic                       first_pending_reg;
    logic [ctmb_pkg::MAP_W-1:0] current_map_reg;
    logic [ctmb_pkg::IDX_W-1:0] pair_idx [4];
    logic [3:0]                 pair_en;
    logic [2:0]                 inc;
    logic [KW:0]                sum;
    logic [ctmb_pkg::MAP_W-1:0] new_map;
    logic                       same_map;
    logic                       take_close;

    // argmax per preceding symbol, ties to the lower successor
    function automatic logic [ctmb_pkg::MAP_W-1:0] build_map(input logic [KW-1:0] c [NC]);
        logic [ctmb_pkg::MAP_W-1:0] m;
        logic [ctmb_pkg::SYM_W-1:0] best;
        m = '0;
        for (int s = 0; s < ctmb_pkg::NUM_SYM; s++)
        begin
            best = '0;
            for (int t = 1; t < ctmb_pkg::NUM_SYM; t++)
            begin
                if (c[s * ctmb_pkg::NUM_SYM + int'(best)] < c[s * ctmb_pkg::NUM_SYM + t])
                begin
                    best = ctmb_pkg::SYM_W'(t);
                end
            end
            m[(ctmb_pkg::NUM_SYM - 1 - s) * ctmb_pkg::SYM_W +: ctmb_pkg::SYM_W] = best;
        end
        return m;
    endfunction

    // map stage: result goes out when the result queue has room
    assign new_map  = build_map(snap_reg);
    assign same_map = !first_pending_reg && (new_map == current_map_reg);
    assign res_push = snap_valid_reg && !res_full;

    assign res.record_bit  = same_map;
    assign res.chunk_map   = same_map ? '0 : new_map;
    assign res.stream_done = snap_eos_reg;

    // count stage: a closing byte waits until the snapshot is free
    assign q_pop      = !q_stat.empty && (!q_item.close || !snap_valid_reg || res_push);
    assign take_close = q_pop && q_item.close;

    // the four transitions of this byte
    always_comb
    begin
        pair_idx[0] = {q_item.prev_sym, q_item.data_byte[7:6]};
        pair_idx[1] = q_item.data_byte[7:4];
        pair_idx[2] = q_item.data_byte[5:2];
        pair_idx[3] = q_item.data_byte[3:0];
        pair_en     = {3'b111, q_item.prev_en};
    end

    // saturating counter update
    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            inc = '0;
            for (int p = 0; p < 4; p++)
            begin
                if (pair_en[p] && (pair_idx[p] == ctmb_pkg::IDX_W'(i)))
                begin
                    inc = inc + 1'b1;
                end
            end
            sum = {1'b0, cnt_reg[i]} + (KW + 1)'(inc);
            cnt_next[i] = (sum > {1'b0, ctmb_pkg::COUNT_MAX}) ? ctmb_pkg::COUNT_MAX
                                                              : sum[KW-1:0];
        end
    end

    // counter table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NC; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (q_pop)
        begin
            for (int i = 0; i < NC; i++)
            begin
                cnt_reg[i] <= q_item.close ? '0 : cnt_next[i];
            end
        end
    end

    // snapshot of a closed chunk
    always_ff @(posedge clk)
    begin
        if (take_close)
        begin
            for (int i = 0; i < NC; i++)
            begin
                snap_reg[i] <= cnt_next[i];
            end
            snap_eos_reg <= q_item.eos;
        end
    end

    // snapshot valid and map history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg    <= 1'b0;
            first_pending_reg <= 1'b1;
            current_map_reg   <= '0;
        end
        else
        begin
            if (take_close)
            begin
                snap_valid_reg <= 1'b1;
            end
            else if (res_push)
            begin
                snap_valid_reg <= 1'b0;
            end
            if (res_push)
            begin
                if (snap_eos_reg)
                begin
                    first_pending_reg <= 1'b1;
                    current_map_reg   <= '0;
                end
                else
                begin
                    first_pending_reg <= 1'b0;
                    current_map_reg   <= new_map;
                end
            end
        end
    end

endmodule

/* sv/chunk_transition_map_builder_unit.sv */
// chunk transition map builder
// input queue side: drive data_byte and end_of_stream with push; a transfer
// happens on a rising edge with push high and full low
// result queue side: while empty is low the oldest record sits on
// record_bit, chunk_map and stream_done; pop with empty low takes it
// chunk length is written by chunk_len_we / chunk_len_wdata; the user must do so only while idle, not enforced
// throughput: one byte per cycle unless a stall holds it, set by the counter
// update in the back end; a chunk close snapshots the counters so the next
// byte follows without a gap while the snapshot is free
// result path: a closing byte goes from the input queue through the counter stage
// snapshot, then the map stage into the result queue
// reset: counters, stream state and queues clear at once, chunk length
// returns to 256, the first map of a stream is always reported as changed
// result stall: records wait in the result queue; once it and the snapshot
// are full, a closing byte holds at the head of the input queue, bytes
// behind it wait there too and full rises when the queue fills
`include "chunk_transition_map_builder_unit_assert.svh"

module chunk_transition_map_builder_unit #(
    parameter int MAX_CHUNK_BYTES = ctmb_pkg::MAX_CHUNK_BYTES_DEF,
    parameter int QUEUE_DEPTH     = ctmb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [ctmb_pkg::BYTE_W-1:0]     data_byte,
    input  logic                            end_of_stream,
    output logic                            empty,
    input  logic                            pop,
    output logic                            record_bit,
    output logic [ctmb_pkg::MAP_W-1:0]      chunk_map,
    output logic                            stream_done,
    input  logic                            chunk_len_we,
    input  logic [ctmb_pkg::CSIZE_W-1:0]    chunk_len_wdata
);

    localparam int IW = $bits(ctmb_pkg::item_t);
    localparam int RW = $bits(ctmb_pkg::result_t);

    logic              mq_push, mq_pop;
    ctmb_pkg::item_t   mq_in, mq_out;
    ctmb_pkg::qstat_t  mq_stat;
    logic              rq_push;
    ctmb_pkg::result_t rq_in, rq_out;
    ctmb_pkg::qstat_t  rq_stat;

    // front: stream state and chunk close decision
    ctmb_front #(
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .data_byte       (data_byte),
        .end_of_stream   (end_of_stream),
        .chunk_len_we    (chunk_len_we),
        .chunk_len_wdata (chunk_len_wdata),
        .q_full          (mq_stat.full),
        .q_push          (mq_push),
        .q_item          (mq_in)
    );

    // queue between front and back
    ctmb_fifo #(
        .WIDTH (IW),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mq_push),
        .wr_data (mq_in),
        .rd_en   (mq_pop),
        .rd_data (mq_out),
        .stat    (mq_stat)
    );

    // back: counters and map builder
    ctmb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (mq_stat),
        .q_item   (mq_out),
        .q_pop    (mq_pop),
        .res_full (rq_stat.full),
        .res_push (rq_push),
        .res      (rq_in)
    );

    // result queue
    ctmb_fifo #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rq_push),
        .wr_data (rq_in),
        .rd_en   (pop),
        .rd_data (rq_out),
        .stat    (rq_stat)
    );

    assign full        = mq_stat.full;
    assign empty       = rq_stat.empty;
    assign record_bit  = rq_out.record_bit;
    assign chunk_map   = rq_out.chunk_map;
    assign stream_done = rq_out.stream_done;

    // checks
    `CTMB_ASSERT_IMPLY(a_rec_map_zero, clk, rst_n, !empty && record_bit, chunk_map == '0,
        "unchanged record carries a nonzero map")
    `CTMB_ASSERT_IMPLY(a_res_room, clk, rst_n, rq_push, !rq_stat.full,
        "result written into a full queue")
    `CTMB_ASSERT_IMPLY(a_item_room, clk, rst_n, mq_pop, !mq_stat.empty,
        "item taken from an empty queue")

endmodule
